// ===== rtl/core/tlpt_pkg.sv =====
// Package for the two-level page table engine: sizes, codes and memory request types.
// Depends on nothing; all files of the engine refer to it by scoped names.
package tlpt_pkg;

  localparam int unsigned NUM_SPACES    = 4;
  localparam int unsigned TABLE_POOL    = 16;
  localparam int unsigned DIR_ENTRIES   = 1024;
  localparam int unsigned TABLE_ENTRIES = 1024;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned SPACE_W = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
  localparam int unsigned TBL_W   = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int unsigned DIR_AW  = SPACE_W + IDX_W;
  localparam int unsigned TBL_AW  = TBL_W + IDX_W;
  localparam int unsigned DIR_DEPTH = NUM_SPACES * DIR_ENTRIES;
  localparam int unsigned TBL_DEPTH = TABLE_POOL * TABLE_ENTRIES;
  localparam int unsigned CNT_W   = 11;

  localparam int unsigned DIR_SHIFT = 22;
  localparam int unsigned TBL_SHIFT = 12;
  localparam logic [31:0] PAGE_MASK = 32'hFFFF_F000;

  typedef enum logic [1:0] {
    FUNC_MAP       = 2'd0,
    FUNC_UNMAP     = 2'd1,
    FUNC_TRANSLATE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_NO_FREE = 2'd2
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [TBL_W-1:0] tbl;
  } dir_entry_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [DIR_AW-1:0] addr;
    dir_entry_t        wdata;
  } dir_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [TBL_AW-1:0] addr;
    logic [31:0]       wdata;
  } tbl_req_t;

endpackage

// ===== rtl/core/tlpt_dir_mem.sv =====
// Directory memory: one entry per address space and directory index.
// Depends on tlpt_pkg for sizes and the request type.
module tlpt_dir_mem (
  input  logic                clk_i,
  input  tlpt_pkg::dir_req_t  req_i,
  output tlpt_pkg::dir_entry_t rdata_o
);

  tlpt_pkg::dir_entry_t mem [tlpt_pkg::DIR_DEPTH];
  tlpt_pkg::dir_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tlpt_tbl_mem.sv =====
// Second-level table memory: all pool tables, one 32-bit entry per table index.
// Depends on tlpt_pkg for sizes and the request type.
module tlpt_tbl_mem (
  input  logic               clk_i,
  input  tlpt_pkg::tbl_req_t req_i,
  output logic [31:0]        rdata_o
);

  logic [31:0] mem [tlpt_pkg::TBL_DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/two_level_page_table_engine_unit.sv =====
// Top level of the two-level page table engine: sequencer, pool bookkeeping, results.
// Depends on tlpt_pkg, tlpt_dir_mem and tlpt_tbl_mem.
//
//  channel   handshake          payload
//  command   start / busy       func_i, space_id_i, virt_addr_i, phys_addr_i, entry_flags_i
//  result    done_o (strobe)    phys_out_o, status_o
//
// A hit on a linked table goes from acceptance to the result strobe through the
// directory read, the table read, then for a map or unmap the write-back. An unknown
// operation or an out-of-range space is answered from idle without a walk. Linking a new
// table clears it first through the single table write port, then rereads the entry.
// After reset the directory is cleared one entry a cycle, every entry, with busy high.
// The receiver cannot stall; busy is high whenever a transaction is in progress.
module two_level_page_table_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [1:0]  space_id_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [11:0] entry_flags_i,
  output logic        done_o,
  output logic [31:0] phys_out_o,
  output logic [1:0]  status_o
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DIR, S_CLR, S_TRD, S_TCHK
  } state_e;

  state_e state_q;

  logic [tlpt_pkg::DIR_AW-1:0] init_q;
  logic [tlpt_pkg::IDX_W-1:0]  clr_q;
  logic [1:0]                  func_q;
  logic [tlpt_pkg::DIR_AW-1:0] dir_addr_q;
  logic [tlpt_pkg::IDX_W-1:0]  tix_q;
  logic [31:0]                 nv_q;
  logic [tlpt_pkg::TBL_W-1:0]  tbl_q;

  logic                        free_q [tlpt_pkg::TABLE_POOL];
  logic [tlpt_pkg::CNT_W-1:0]  cnt_q  [tlpt_pkg::TABLE_POOL];

  logic        done_q;
  logic [31:0] phys_q;
  logic [1:0]  status_q;

  tlpt_pkg::dir_req_t   dir_req;
  tlpt_pkg::tbl_req_t   tbl_req;
  tlpt_pkg::dir_entry_t dir_rd;
  logic [31:0]          tbl_rd;

  logic                       free_found;
  logic [tlpt_pkg::TBL_W-1:0] free_idx;
  logic                       accept;
  logic                       space_bad;
  logic [tlpt_pkg::DIR_AW-1:0] in_dir_addr;
  logic [tlpt_pkg::CNT_W-1:0] cur_cnt;
  logic [tlpt_pkg::CNT_W-1:0] unmap_cnt;
  logic                       unmap_dec;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign space_bad = (7'(space_id_i) >= 7'(tlpt_pkg::NUM_SPACES));
  assign in_dir_addr = {tlpt_pkg::SPACE_W'(space_id_i),
                        virt_addr_i[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::IDX_W]};

  // Lowest free table in the pool.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int t = tlpt_pkg::TABLE_POOL - 1; t >= 0; t--) begin
      if (free_q[t]) begin
        free_found = 1'b1;
        free_idx   = tlpt_pkg::TBL_W'(t);
      end
    end
  end

  assign cur_cnt   = cnt_q[tbl_q];
  assign unmap_dec = tbl_rd[0] && (cur_cnt != '0);
  assign unmap_cnt = cur_cnt - tlpt_pkg::CNT_W'(unmap_dec);

  always_comb begin
    dir_req = '0;
    tbl_req = '0;
    unique case (state_q)
      S_INIT: begin
        dir_req.we   = 1'b1;
        dir_req.addr = init_q;
      end
      S_IDLE: begin
        dir_req.re   = accept;
        dir_req.addr = in_dir_addr;
      end
      S_DIR: begin
        if (dir_rd.valid) begin
          if (func_q == tlpt_pkg::FUNC_MAP || func_q == tlpt_pkg::FUNC_UNMAP ||
              func_q == tlpt_pkg::FUNC_TRANSLATE) begin
            tbl_req.re   = 1'b1;
            tbl_req.addr = {dir_rd.tbl, tix_q};
          end
        end else if (func_q == tlpt_pkg::FUNC_MAP && free_found) begin
          dir_req.we          = 1'b1;
          dir_req.addr        = dir_addr_q;
          dir_req.wdata.valid = 1'b1;
          dir_req.wdata.tbl   = free_idx;
        end
      end
      S_CLR: begin
        tbl_req.we   = 1'b1;
        tbl_req.addr = {tbl_q, clr_q};
      end
      S_TRD: begin
        tbl_req.re   = 1'b1;
        tbl_req.addr = {tbl_q, tix_q};
      end
      S_TCHK: begin
        tbl_req.addr = {tbl_q, tix_q};
        if (func_q == tlpt_pkg::FUNC_MAP) begin
          tbl_req.we    = 1'b1;
          tbl_req.wdata = nv_q;
        end else if (func_q == tlpt_pkg::FUNC_UNMAP) begin
          tbl_req.we = 1'b1;
          // A table with no present entry left is unlinked from its directory entry.
          if (unmap_cnt == '0) begin
            dir_req.we   = 1'b1;
            dir_req.addr = dir_addr_q;
          end
        end
      end
      default: begin
        dir_req = '0;
      end
    endcase
  end

  tlpt_dir_mem u_dir_mem (
    .clk_i  (clk_i),
    .req_i  (dir_req),
    .rdata_o(dir_rd)
  );

  tlpt_tbl_mem u_tbl_mem (
    .clk_i  (clk_i),
    .req_i  (tbl_req),
    .rdata_o(tbl_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      init_q   <= '0;
      clr_q    <= '0;
      done_q   <= 1'b0;
      phys_q   <= '0;
      status_q <= '0;
      func_q   <= '0;
      dir_addr_q <= '0;
      tix_q    <= '0;
      nv_q     <= '0;
      tbl_q    <= '0;
      for (int t = 0; t < tlpt_pkg::TABLE_POOL; t++) begin
        free_q[t] <= 1'b1;
        cnt_q[t]  <= '0;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + 1'b1;
          if (init_q == tlpt_pkg::DIR_AW'(tlpt_pkg::DIR_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_q     <= func_i;
            dir_addr_q <= in_dir_addr;
            tix_q      <= virt_addr_i[tlpt_pkg::TBL_SHIFT +: tlpt_pkg::IDX_W];
            nv_q       <= phys_addr_i | {20'd0, entry_flags_i};
            if (func_i != tlpt_pkg::FUNC_MAP && func_i != tlpt_pkg::FUNC_UNMAP &&
                func_i != tlpt_pkg::FUNC_TRANSLATE) begin
              done_q   <= 1'b1;
              phys_q   <= '0;
              status_q <= tlpt_pkg::ST_OK;
            end else if (space_bad) begin
              done_q   <= 1'b1;
              phys_q   <= '0;
              status_q <= tlpt_pkg::ST_MISS;
            end else begin
              state_q <= S_DIR;
            end
          end
        end
        S_DIR: begin
          if (dir_rd.valid) begin
            tbl_q   <= dir_rd.tbl;
            state_q <= S_TCHK;
          end else if (func_q == tlpt_pkg::FUNC_MAP) begin
            if (free_found) begin
              tbl_q            <= free_idx;
              free_q[free_idx] <= 1'b0;
              cnt_q[free_idx]  <= '0;
              clr_q            <= '0;
              state_q          <= S_CLR;
            end else begin
              done_q   <= 1'b1;
              phys_q   <= '0;
              status_q <= tlpt_pkg::ST_NO_FREE;
              state_q  <= S_IDLE;
            end
          end else begin
            done_q   <= 1'b1;
            phys_q   <= '0;
            status_q <= tlpt_pkg::ST_MISS;
            state_q  <= S_IDLE;
          end
        end
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == tlpt_pkg::IDX_W'(tlpt_pkg::TABLE_ENTRIES - 1)) begin
            state_q <= S_TRD;
          end
        end
        S_TRD: begin
          state_q <= S_TCHK;
        end
        S_TCHK: begin
          done_q  <= 1'b1;
          phys_q  <= '0;
          status_q <= tlpt_pkg::ST_OK;
          state_q <= S_IDLE;
          if (func_q == tlpt_pkg::FUNC_MAP) begin
            if (tbl_rd[0] && !nv_q[0]) begin
              cnt_q[tbl_q] <= cur_cnt - 1'b1;
            end else if (!tbl_rd[0] && nv_q[0]) begin
              cnt_q[tbl_q] <= cur_cnt + 1'b1;
            end
          end else if (func_q == tlpt_pkg::FUNC_UNMAP) begin
            cnt_q[tbl_q] <= unmap_cnt;
            if (unmap_cnt == '0) begin
              free_q[tbl_q] <= 1'b1;
            end
          end else if (tbl_rd[0]) begin
            phys_q <= tbl_rd & tlpt_pkg::PAGE_MASK;
          end else begin
            status_q <= tlpt_pkg::ST_MISS;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o     = done_q;
  assign phys_out_o = phys_q;
  assign status_o   = status_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != tlpt_pkg::ST_OK |-> phys_out_o == '0)
    else $error("failed transaction returned a nonzero address");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o || busy)
    else $error("accepted transaction neither answered nor in progress");

  a_linked_not_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TCHK |-> !free_q[tbl_q])
    else $error("table in use is marked free");

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |=> !done_o)
    else $error("result strobe while a table is being cleared");

endmodule

// ===== tb/two_level_page_table_engine_unit_checker.sv =====
// Checker for the two-level page table engine: watches the command and result channels.
// It keeps its own copy of the page tables and compares every result field by field.
// Depends on tlpt_pkg.
module two_level_page_table_engine_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  func_i,
  input  logic [1:0]  space_id_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [11:0] entry_flags_i,
  input  logic        done_i,
  input  logic [31:0] phys_out_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlpt_pkg::*;

  typedef struct packed {
    logic [31:0] phys;
    logic [1:0]  status;
  } walk_result_t;

  logic              dir_linked [DIR_DEPTH];
  logic [TBL_W-1:0]  dir_tbl    [DIR_DEPTH];
  logic [31:0]       page_words [TBL_DEPTH];
  logic              tbl_free   [TABLE_POOL];
  int unsigned       tbl_live   [TABLE_POOL];
  walk_result_t      walk_queue [$];
  int                mismatches;

  initial begin
    for (int i = 0; i < DIR_DEPTH; i++) begin
      dir_linked[i] = 1'b0;
      dir_tbl[i] = '0;
    end
    for (int t = 0; t < TABLE_POOL; t++) begin
      tbl_free[t] = 1'b1;
      tbl_live[t] = 0;
    end
    mismatches = 0;
  end

  assign fail_count_o = mismatches;
  assign pending_o    = walk_queue.size();

  function automatic walk_result_t walk_tables(logic [1:0] op, logic [1:0] space,
                                               logic [31:0] va, logic [31:0] pa,
                                               logic [11:0] flags);
    walk_result_t r;
    int d;
    int t;
    int e;
    logic was;
    logic [31:0] word;
    r = '{phys: '0, status: ST_OK};
    d = space * DIR_ENTRIES + va[31:22];
    if (op == 2'd3) return r;
    if (space >= NUM_SPACES) begin
      r.status = ST_MISS;
      return r;
    end
    case (func_e'(op))
      FUNC_MAP: begin
        if (dir_linked[d]) begin
          t = dir_tbl[d];
        end else begin
          t = -1;
          for (int k = TABLE_POOL - 1; k >= 0; k--) if (tbl_free[k]) t = k;
          if (t < 0) begin
            r.status = ST_NO_FREE;
            return r;
          end
          for (int k = 0; k < TABLE_ENTRIES; k++) page_words[t * TABLE_ENTRIES + k] = '0;
          tbl_free[t] = 1'b0;
          tbl_live[t] = 0;
          dir_linked[d] = 1'b1;
          dir_tbl[d] = t[TBL_W-1:0];
        end
        e = t * TABLE_ENTRIES + va[21:12];
        was = page_words[e][0];
        word = pa | {20'd0, flags};
        page_words[e] = word;
        if (was && !word[0]) tbl_live[t]--;
        if (!was && word[0]) tbl_live[t]++;
      end
      FUNC_UNMAP: begin
        if (!dir_linked[d]) begin
          r.status = ST_MISS;
        end else begin
          t = dir_tbl[d];
          e = t * TABLE_ENTRIES + va[21:12];
          if (page_words[e][0] && tbl_live[t] > 0) tbl_live[t]--;
          page_words[e] = '0;
          if (tbl_live[t] == 0) begin
            tbl_free[t] = 1'b1;
            dir_linked[d] = 1'b0;
            dir_tbl[d] = '0;
          end
        end
      end
      default: begin
        if (!dir_linked[d]) begin
          r.status = ST_MISS;
        end else begin
          word = page_words[dir_tbl[d] * TABLE_ENTRIES + va[21:12]];
          if (!word[0]) r.status = ST_MISS;
          else r.phys = word & PAGE_MASK;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    walk_result_t want;
    if (rst_ni) begin
      // Results come from earlier transactions, so compare before queuing the new one.
      if (done_i) begin
        if (walk_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: phys_out %h status %0d", phys_out_i, status_i);
        end else begin
          want = walk_queue.pop_front();
          if (want.phys !== phys_out_i || want.status !== status_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected phys_out %h status %0d, got phys_out %h status %0d",
                       want.phys, want.status, phys_out_i, status_i);
          end
        end
      end
      if (start_i && !busy_i)
        walk_queue.push_back(walk_tables(func_i, space_id_i, virt_addr_i, phys_addr_i,
                                         entry_flags_i));
    end
  end

endmodule

// ===== tb/two_level_page_table_engine_unit_test.sv =====
// Testbench top for the two-level page table engine: clock, reset, command stimulus, verdict.
// Depends on tlpt_pkg, two_level_page_table_engine_unit and its checker module.
module two_level_page_table_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tlpt_pkg::*;

  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 700;
  localparam int CALM_ITEMS   = 100;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = '0;
  logic [1:0]  space_id_i = '0;
  logic [31:0] virt_addr_i = '0;
  logic [31:0] phys_addr_i = '0;
  logic [11:0] entry_flags_i = '0;
  logic        done_o;
  logic [31:0] phys_out_o;
  logic [1:0]  status_o;
  int          fail_count;
  int          pending;
  longint      cycles = 0;
  logic [9:0]  dir_pick [24];
  logic [9:0]  tbl_pick [8];

  two_level_page_table_engine_unit uut (.*);

  two_level_page_table_engine_unit_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .func_i, .space_id_i,
    .virt_addr_i, .phys_addr_i, .entry_flags_i, .done_i(done_o), .phys_out_i(phys_out_o),
    .status_i(status_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL two_level_page_table_engine_unit");
      $finish;
    end
  end

  // Drives one transaction and returns at the edge that accepts it.
  task automatic issue(logic [1:0] op, logic [1:0] space, logic [31:0] va, logic [31:0] pa,
                       logic [11:0] flags);
    start <= 1'b1;
    func_i <= op;
    space_id_i <= space;
    virt_addr_i <= va;
    phys_addr_i <= pa;
    entry_flags_i <= flags;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic maybe_idle(bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_va();
    logic [9:0] dix;
    logic [9:0] tix;
    dix = ($urandom_range(0, 19) == 0) ? 10'($urandom) : dir_pick[$urandom_range(0, 23)];
    tix = ($urandom_range(0, 9) == 0) ? 10'($urandom) : tbl_pick[$urandom_range(0, 7)];
    return {dix, tix, 12'($urandom)};
  endfunction

  initial begin
    logic [1:0]  op;
    logic [11:0] flags;
    int          roll;
    dir_pick[0] = 10'd0;
    dir_pick[1] = 10'h3FF;
    for (int i = 2; i < 24; i++) dir_pick[i] = 10'($urandom);
    tbl_pick[0] = 10'd0;
    tbl_pick[1] = 10'h3FF;
    for (int i = 2; i < 8; i++) tbl_pick[i] = 10'($urandom);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, a map without the present flag, misses and an unknown operation.
    issue(FUNC_MAP, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    issue(FUNC_TRANSLATE, 2'd3, 32'hFFFF_FFFF, '0, '0);
    issue(FUNC_TRANSLATE, 2'd3, 32'hFFFF_E000, '0, '0);
    issue(FUNC_UNMAP, 2'd3, 32'hFFFF_E000, '0, '0);
    issue(FUNC_TRANSLATE, 2'd0, 32'h0000_0000, '0, '0);
    issue(FUNC_UNMAP, 2'd0, 32'h0000_0000, '0, '0);
    issue(FUNC_MAP, 2'd0, 32'h0000_0000, 32'h0000_0000, 12'h000);
    issue(FUNC_TRANSLATE, 2'd0, 32'h0000_0000, '0, '0);
    issue(FUNC_MAP, 2'd0, 32'h0000_0FFF, 32'h1234_5000, 12'h007);
    issue(FUNC_TRANSLATE, 2'd0, 32'h0000_0ABC, '0, '0);
    issue(FUNC_MAP, 2'd0, 32'h0000_0000, 32'hABCD_E000, 12'h006);
    issue(FUNC_UNMAP, 2'd0, 32'h0000_0000, '0, '0);
    issue(FUNC_TRANSLATE, 2'd0, 32'h0000_0000, '0, '0);
    issue(FUNC_UNKNOWN, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    // Fill the pool across spaces; the last two maps find no free table.
    for (int i = 0; i < 17; i++)
      issue(FUNC_MAP, 2'(i), {10'(i + 1), 10'(i), 12'h0}, 32'($urandom), 12'h001);
    issue(FUNC_UNMAP, 2'd3, 32'hFFFF_FFFF, '0, '0);
    for (int i = 0; i < 16; i++)
      issue(FUNC_UNMAP, 2'(i), {10'(i + 1), 10'(i), 12'h0}, '0, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) op = FUNC_MAP;
      else if (roll < 65) op = FUNC_UNMAP;
      else if (roll < 95) op = FUNC_TRANSLATE;
      else op = FUNC_UNKNOWN;
      flags = 12'($urandom);
      if ($urandom_range(0, 4) != 0) flags[0] = 1'b1;
      issue(op, 2'($urandom), pick_va(), $urandom, flags);
      maybe_idle(n < RANDOM_ITEMS - CALM_ITEMS);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS two_level_page_table_engine_unit");
    end else begin
      $display("FAIL two_level_page_table_engine_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tlpt_pkg.sv
rtl/core/tlpt_dir_mem.sv
rtl/core/tlpt_tbl_mem.sv
rtl/core/two_level_page_table_engine_unit.sv
tb/two_level_page_table_engine_unit_checker.sv
tb/two_level_page_table_engine_unit_test.sv
